// ===== src/modbus_ascii_register_slave_macros.svh =====
// assertion macros for the modbus ascii register slave
`ifndef MODBUS_ASCII_REGISTER_SLAVE_MACROS_SVH
`define MODBUS_ASCII_REGISTER_SLAVE_MACROS_SVH
`ifndef SYNTHESIS
`define MASR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MASR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MASR_ASSERT_IMPL(lbl, ante, cons)
`define MASR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/masr_pkg.sv =====
// shared constants and helper functions of the modbus ascii register slave
`timescale 1ns / 1ps
`default_nettype none
package masr_pkg;
    localparam int REG_COUNT   = 64;
    localparam int FRAME_BYTES = 256;
    localparam int RF_AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int FB_AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int FC_W  = $clog2(FRAME_BYTES + 1);

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] FN_READ  = 8'h03;
    localparam logic [7:0] FN_WR1   = 8'h06;
    localparam logic [7:0] FN_WRN   = 8'h10;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TX    = 5'b00010,
        S_WM_HI = 5'b00100,
        S_WM_LO = 5'b01000,
        S_WM_WR = 5'b10000
    } t_state;

    // power-on contents of the register file
    function automatic logic [15:0] preset(input logic [RF_AW-1:0] idx);
        logic [15:0] v;
        case (idx)
            RF_AW'(0):  v = 16'd723;
            RF_AW'(1):  v = 16'd3678;
            RF_AW'(2):  v = 16'd528;
            RF_AW'(3):  v = 16'd1899;
            RF_AW'(4):  v = 16'd523;
            RF_AW'(5):  v = 16'd1278;
            RF_AW'(6):  v = 16'd1;
            RF_AW'(9):  v = 16'd1;
            RF_AW'(11): v = 16'd15;
            RF_AW'(12): v = 16'd13;
            default:    v = 16'd0;
        endcase
        if (int'(idx) >= 13 || int'(idx) >= REG_COUNT) v = 16'd0;
        return v;
    endfunction

    // {ok, value} of an ascii hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    function automatic logic [7:0] hex_chr(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
    endfunction
endpackage
`default_nettype wire

// ===== src/masr_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module masr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/modbus_ascii_register_slave.sv =====
// modbus ascii slave over a 16-bit register file
//
// channel  | valid       | ready        | payload
// input    | i_in_valid  | o_in_ready   | i_req_type, i_rx_char
// output   | o_out_valid | i_out_ready  | o_tx_char, o_last_char
//
// a received character is handled in the idle state; a pull with a pending reply
// goes through the register file ram read, then the output register is loaded
// write multiple walks the frame buffer ram per register in S_WM_HI, S_WM_LO
// and S_WM_WR (two buffer reads and one register write), as it has one read port
// reset is synchronous; register presets come from valid bits, no clearing pass
// a waiting result blocks only a new transfer in the cycle it is not taken
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_ascii_register_slave_macros.svh"
module modbus_ascii_register_slave (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_rx_char,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic      [7:0] o_tx_char,
    output logic            o_last_char
);
    localparam int RA = masr_pkg::RF_AW;
    localparam int FA = masr_pkg::FB_AW;
    localparam int FC = masr_pkg::FC_W;

    masr_pkg::t_state r_state, n_state;

    // receive side
    logic          r_in_frame, n_in_frame;
    logic          r_phase, n_phase;
    logic [3:0]    r_hinib, n_hinib;
    logic [7:0]    r_rx_lrc, n_rx_lrc;
    logic [FC-1:0] r_fcount, n_fcount;
    logic [7:0]    r_hdr [7];   // copies of frame bytes 0..6
    logic [7:0]    n_hdr [7];

    // transmit side
    logic          r_tx_active, n_tx_active;
    logic [9:0]    r_seq, n_seq;
    logic [7:0]    r_tx_lrc, n_tx_lrc;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_tx_char, n_tx_char;
    logic          r_last, n_last;

    // register file presets overlay
    logic [masr_pkg::REG_COUNT-1:0] r_rf_valid, n_rf_valid;
    logic          r_ra_ok;
    logic [RA-1:0] r_ra_idx;

    // write multiple walk
    logic [6:0]    r_wm_i, n_wm_i;
    logic [7:0]    r_wm_hi, n_wm_hi;

    // ram ports
    logic          fb_we;
    logic [FA-1:0] fb_waddr, fb_raddr;
    logic [7:0]    fb_wdata, fb_rdata;
    logic          rf_we;
    logic [RA-1:0] rf_waddr, rf_raddr;
    logic [15:0]   rf_wdata, rf_rdata;

    masr_ram #(.WIDTH(8), .DEPTH(masr_pkg::FRAME_BYTES)) u_frame_ram (
        .i_clk(i_clk), .i_we(fb_we), .i_waddr(fb_waddr), .i_wdata(fb_wdata),
        .i_raddr(fb_raddr), .o_rdata(fb_rdata)
    );
    masr_ram #(.WIDTH(16), .DEPTH(masr_pkg::REG_COUNT)) u_reg_ram (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_raddr(rf_raddr), .o_rdata(rf_rdata)
    );

    logic [15:0] w_addr, w_qty;
    logic [7:0]  w_fn, w_bc;
    assign w_fn   = r_hdr[1];
    assign w_addr = {r_hdr[2], r_hdr[3]};
    assign w_qty  = {r_hdr[4], r_hdr[5]};
    assign w_bc   = r_hdr[6];

    // reply length in bytes and the register address for the current sequence
    logic [8:0]  w_len;
    logic [9:0]  w_len2, w_k, w_j;
    logic [16:0] w_ra;
    assign w_len  = (w_fn == masr_pkg::FN_READ) ? (9'd3 + {w_qty[7:0], 1'b0}) : 9'd6;
    assign w_len2 = {w_len, 1'b0};
    assign w_k    = (r_seq - 10'd1) >> 1;
    assign w_j    = w_k - 10'd3;
    assign w_ra   = {1'b0, w_addr} + {8'd0, w_j[9:1]};
    assign rf_raddr = w_ra[RA-1:0];

    logic [15:0] w_rval;
    assign w_rval = !r_ra_ok ? 16'd0 :
                    (r_rf_valid[r_ra_idx] ? rf_rdata : masr_pkg::preset(r_ra_idx));

    logic [16:0] w_wm_a;
    logic [8:0]  w_fb_rd;
    assign w_wm_a  = {1'b0, w_addr} + {10'd0, r_wm_i};
    assign w_fb_rd = 9'd7 + {1'b0, r_wm_i, 1'b0} + ((r_state == masr_pkg::S_WM_LO) ? 9'd1 : 9'd0);
    assign fb_raddr = w_fb_rd[FA-1:0];

    assign o_in_ready  = (r_state == masr_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_tx_char   = r_tx_char;
    assign o_last_char = r_last;

    always_comb begin
        logic [4:0]  hv;
        logic [7:0]  b, byte_v;
        logic [FC-1:0] fn_n;
        n_state = r_state;
        n_in_frame = r_in_frame;
        n_phase = r_phase;
        n_hinib = r_hinib;
        n_rx_lrc = r_rx_lrc;
        n_fcount = r_fcount;
        n_hdr = r_hdr;
        n_tx_active = r_tx_active;
        n_seq = r_seq;
        n_tx_lrc = r_tx_lrc;
        n_out_valid = r_out_valid && !i_out_ready;
        n_tx_char = r_tx_char;
        n_last = r_last;
        n_rf_valid = r_rf_valid;
        n_wm_i = r_wm_i;
        n_wm_hi = r_wm_hi;
        fb_we = 1'b0;
        fb_waddr = r_fcount[FA-1:0];
        fb_wdata = 8'd0;
        rf_we = 1'b0;
        rf_waddr = w_addr[RA-1:0];
        rf_wdata = w_qty;
        hv = masr_pkg::hex_val(i_rx_char);
        b = {r_hinib, hv[3:0]};
        byte_v = 8'd0;
        fn_n = r_fcount - FC'(1);
        case (r_state)
            masr_pkg::S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    if (i_req_type) begin
                        if (r_tx_active) n_state = masr_pkg::S_TX;
                    end else if (i_rx_char == masr_pkg::CH_COLON) begin
                        n_in_frame = 1'b1;
                        n_fcount = '0;
                        n_phase = 1'b0;
                        n_hinib = 4'd0;
                        n_rx_lrc = 8'd0;
                        n_tx_active = 1'b0;
                    end else if (r_in_frame) begin
                        if (i_rx_char == masr_pkg::CH_CR || i_rx_char == masr_pkg::CH_LF) begin
                            n_in_frame = 1'b0;
                            if (!r_phase && r_fcount != '0 && r_rx_lrc == 8'd0) begin
                                if (w_fn == masr_pkg::FN_READ) begin
                                    if (fn_n == FC'(6) && w_qty >= 16'd1 && w_qty <= 16'd125) begin
                                        n_tx_active = 1'b1;
                                        n_seq = 10'd0;
                                        n_tx_lrc = 8'd0;
                                    end
                                end else if (w_fn == masr_pkg::FN_WR1) begin
                                    if (fn_n == FC'(6)) begin
                                        if ({16'd0, w_addr} < 32'(masr_pkg::REG_COUNT)) begin
                                            rf_we = 1'b1;
                                            n_rf_valid[w_addr[RA-1:0]] = 1'b1;
                                        end
                                        n_tx_active = 1'b1;
                                        n_seq = 10'd0;
                                        n_tx_lrc = 8'd0;
                                    end
                                end else if (w_fn == masr_pkg::FN_WRN) begin
                                    if (fn_n >= FC'(7) && w_qty >= 16'd1 && w_qty <= 16'd123
                                            && {9'd0, w_bc} == {w_qty[15:0], 1'b0}
                                            && {{(32-FC){1'b0}}, fn_n} == 32'd7 + {24'd0, w_bc})
                                    begin
                                        n_wm_i = 7'd0;
                                        n_state = masr_pkg::S_WM_HI;
                                    end
                                end
                            end
                        end else if (!hv[4]) begin
                            n_in_frame = 1'b0;
                        end else if (!r_phase) begin
                            n_hinib = hv[3:0];
                            n_phase = 1'b1;
                        end else begin
                            n_phase = 1'b0;
                            if ({{(32-FC){1'b0}}, r_fcount} >= 32'(masr_pkg::FRAME_BYTES)) begin
                                n_in_frame = 1'b0;
                            end else begin
                                fb_we = 1'b1;
                                fb_wdata = b;
                                if (r_fcount < FC'(7)) n_hdr[r_fcount[2:0]] = b;
                                n_fcount = r_fcount + FC'(1);
                                n_rx_lrc = r_rx_lrc + b;
                            end
                        end
                    end
                end
            end
            masr_pkg::S_TX: begin
                n_state = masr_pkg::S_IDLE;
                n_out_valid = 1'b1;
                n_last = 1'b0;
                if (w_k < 10'd2) byte_v = r_hdr[w_k[0]];
                else if (w_fn != masr_pkg::FN_READ)
                    byte_v = (w_k[2:0] == 3'd7) ? 8'd0 : r_hdr[w_k[2:0]];
                else if (w_k == 10'd2) byte_v = {w_qty[6:0], 1'b0};
                else byte_v = w_j[0] ? w_rval[7:0] : w_rval[15:8];
                if (r_seq == 10'd0) begin
                    n_tx_char = masr_pkg::CH_COLON;
                end else if (r_seq <= w_len2) begin
                    if (!r_seq[0]) begin
                        n_tx_char = masr_pkg::hex_chr(byte_v[3:0]);
                        n_tx_lrc = r_tx_lrc + byte_v;
                    end else begin
                        n_tx_char = masr_pkg::hex_chr(byte_v[7:4]);
                    end
                end else if (r_seq <= w_len2 + 10'd2) begin
                    b = 8'd0 - r_tx_lrc;
                    n_tx_char = (r_seq == w_len2 + 10'd1) ? masr_pkg::hex_chr(b[7:4])
                                                         : masr_pkg::hex_chr(b[3:0]);
                end else if (r_seq == w_len2 + 10'd3) begin
                    n_tx_char = masr_pkg::CH_CR;
                end else begin
                    n_tx_char = masr_pkg::CH_LF;
                    n_last = 1'b1;
                    n_tx_active = 1'b0;
                end
                n_seq = r_seq + 10'd1;
            end
            masr_pkg::S_WM_HI: n_state = masr_pkg::S_WM_LO;
            masr_pkg::S_WM_LO: begin
                n_wm_hi = fb_rdata;
                n_state = masr_pkg::S_WM_WR;
            end
            masr_pkg::S_WM_WR: begin
                rf_waddr = w_wm_a[RA-1:0];
                rf_wdata = {r_wm_hi, fb_rdata};
                if ({15'd0, w_wm_a} < 32'(masr_pkg::REG_COUNT)) begin
                    rf_we = 1'b1;
                    n_rf_valid[w_wm_a[RA-1:0]] = 1'b1;
                end
                n_wm_i = r_wm_i + 7'd1;
                if ({9'd0, r_wm_i + 7'd1} == w_qty) begin
                    n_state = masr_pkg::S_IDLE;
                    n_tx_active = 1'b1;
                    n_seq = 10'd0;
                    n_tx_lrc = 8'd0;
                end else begin
                    n_state = masr_pkg::S_WM_HI;
                end
            end
            default: n_state = masr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= masr_pkg::S_IDLE;
            r_in_frame <= 1'b0;
            r_phase <= 1'b0;
            r_hinib <= 4'd0;
            r_rx_lrc <= 8'd0;
            r_fcount <= '0;
            r_tx_active <= 1'b0;
            r_seq <= 10'd0;
            r_tx_lrc <= 8'd0;
            r_out_valid <= 1'b0;
            r_rf_valid <= '0;
        end else begin
            r_state <= n_state;
            r_in_frame <= n_in_frame;
            r_phase <= n_phase;
            r_hinib <= n_hinib;
            r_rx_lrc <= n_rx_lrc;
            r_fcount <= n_fcount;
            r_tx_active <= n_tx_active;
            r_seq <= n_seq;
            r_tx_lrc <= n_tx_lrc;
            r_out_valid <= n_out_valid;
            r_rf_valid <= n_rf_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
        r_tx_char <= n_tx_char;
        r_last <= n_last;
        r_wm_i <= n_wm_i;
        r_wm_hi <= n_wm_hi;
        r_ra_ok <= ({15'd0, w_ra} < 32'(masr_pkg::REG_COUNT));
        r_ra_idx <= w_ra[RA-1:0];
    end

    `MASR_ASSERT_NEXT(a_tx_loads_out, r_state == masr_pkg::S_TX, r_out_valid)
    `MASR_ASSERT_IMPL(a_last_is_lf, r_out_valid && r_last, r_tx_char == masr_pkg::CH_LF)
    `MASR_ASSERT_NEXT(a_walk_arms, r_state == masr_pkg::S_WM_WR && {9'd0, r_wm_i + 7'd1} == w_qty, r_tx_active && r_seq == 10'd0)
endmodule
`default_nettype wire
